FILE: design/rdcd_pkg.sv
`default_nettype none
package rdcd_pkg;

  localparam int ModeCountDefault = 3;

  localparam logic [7:0] CodeFwd     = 8'hF1;
  localparam logic [7:0] CodeBack    = 8'hF2;
  localparam logic [7:0] CodeStop    = 8'hF3;
  localparam logic [7:0] CodeTilt    = 8'hF4;
  localparam logic [7:0] CodeStopAll = 8'hF5;
  localparam int         HornBit     = 5;

  localparam logic [2:0] RegAngleCenter   = 3'd0;
  localparam logic [2:0] RegAngleRanges   = 3'd1;
  localparam logic [2:0] RegThrottleRanges = 3'd2;
  localparam logic [2:0] RegTurnLimits    = 3'd3;
  localparam logic [2:0] RegDriveLimits   = 3'd4;
  localparam logic [2:0] RegLinkTimeout   = 3'd5;

  localparam logic [7:0]  AngleCenterRst    = 8'd128;
  localparam logic [31:0] AngleRangesRst    = 32'hFF00_8180;
  localparam logic [31:0] ThrottleRangesRst = 32'hFF00_FF00;
  localparam logic [15:0] TurnLimitsRst     = 16'hFF00;
  localparam logic [15:0] DriveLimitsRst    = 16'hFF00;
  localparam logic [15:0] LinkTimeoutRst    = 16'd1000;

  localparam logic [2:0]  DriveMode = 3'd2;
  localparam logic [1:0]  DirFwd    = 2'b01;
  localparam logic [1:0]  DirBack   = 2'b11;
  localparam logic [1:0]  DirNone   = 2'b00;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } rdcd_state_t;

  function automatic logic [7:0] abs9(input logic [8:0] v);
    logic [8:0] n;
    n = -v;
    return v[8] ? n[7:0] : v[7:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/remote_drive_command_decoder_top.sv
`default_nettype none
// Remote drive command decoder. Each input beat is either a four-byte remote
// frame (in_tuser = 0) or a one-millisecond tick (in_tuser = 1), and each gives
// exactly one result beat. Frames and ticks that need no speed rescaling go
// from acceptance straight to the output state, which loads the result
// register once it is free. A forward, back or spin frame in mode 2 rescales
// its speed with a bit-serial shift-add multiplier followed by a restoring
// bit-serial divider, unless the input range is empty, when both are skipped.
// One item is in work at a time; the result register lets the next item be
// taken while the previous result waits. Configuration writes are always
// accepted.
module remote_drive_command_decoder_top
  import rdcd_pkg::*;
#(
  parameter int MODE_COUNT = ModeCountDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // direction_code, throttle, steer_angle, button_bits
  input  wire logic [31:0] in_tdata,
  // op
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // speed_write, motor_speed, direction_write, left_wheel_dir,
  // right_wheel_dir, link_reset, current_mode, zero fill
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [3:0] ModeCountW = 4'(MODE_COUNT);

  rdcd_state_t state_r, state_nxt;

  logic [7:0]  angle_center_r;
  logic [31:0] angle_ranges_r;
  logic [31:0] throttle_ranges_r;
  logic [15:0] turn_limits_r;
  logic [15:0] drive_limits_r;
  logic [15:0] link_timeout_r;

  logic [2:0]  mode_r;
  logic        prev_horn_r;
  logic [15:0] silent_r;

  logic        spd_w_r, dir_w_r, lrst_r;
  logic [1:0]  ldir_r, rdir_r;
  logic        neg_r;
  logic [7:0]  out_lo_r, mplier_r, den_r, rem_r;
  logic [15:0] mcand_r, prod_r, qr_r;
  logic [3:0]  cnt_r;

  logic        out_tvalid_r;
  logic [23:0] out_tdata_r;

  // input decode
  logic [7:0]  code, thr, ang, btn;
  logic        horn, drive, advance, accept, mode2, timeout;
  logic [3:0]  mode_inc;
  logic [2:0]  mode_new;
  logic [15:0] silent_inc;
  logic [7:0]  x_sel, in_lo_sel, in_hi_sel, o_lo_sel, o_hi_sel;
  logic        scale, f_spd_w, f_dir_w, f_lrst;
  logic [1:0]  f_ldir, f_rdir;
  logic [8:0]  a_diff, b_diff, d_diff;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign code = in_tdata[7:0];
  assign thr  = in_tdata[15:8];
  assign ang  = in_tdata[23:16];
  assign btn  = in_tdata[31:24];
  assign horn = btn[HornBit];

  assign drive    = (code == CodeFwd) || (code == CodeBack) || (code == CodeStop);
  assign advance  = (drive || code == CodeTilt) && horn && !prev_horn_r;
  assign mode_inc = {1'b0, mode_r} + 4'd1;
  assign mode_new = !advance ? mode_r : ((mode_inc == ModeCountW) ? 3'd0 : mode_inc[2:0]);
  assign mode2    = (mode_new == DriveMode);

  assign silent_inc = (silent_r == 16'hFFFF) ? silent_r : silent_r + 16'd1;
  assign timeout    = silent_inc > link_timeout_r;

  always_comb begin
    scale     = 1'b0;
    f_spd_w   = 1'b0;
    f_dir_w   = 1'b0;
    f_lrst    = 1'b0;
    f_ldir    = DirNone;
    f_rdir    = DirNone;
    x_sel     = ang;
    in_lo_sel = angle_ranges_r[7:0];
    in_hi_sel = angle_ranges_r[15:8];
    o_lo_sel  = turn_limits_r[7:0];
    o_hi_sel  = turn_limits_r[15:8];
    if (in_tuser) begin
      f_lrst  = timeout;
      f_spd_w = timeout && (mode_r == DriveMode);
    end else if (drive) begin
      f_spd_w = mode2;
      if (mode2) begin
        priority if (ang < angle_center_r) begin
          scale  = 1'b1;
          f_ldir = DirBack;
          f_rdir = DirFwd;
        end else if (ang > angle_center_r) begin
          scale     = 1'b1;
          in_lo_sel = angle_ranges_r[23:16];
          in_hi_sel = angle_ranges_r[31:24];
          f_ldir    = DirFwd;
          f_rdir    = DirBack;
        end else if (code == CodeFwd) begin
          scale     = 1'b1;
          x_sel     = thr;
          in_lo_sel = throttle_ranges_r[7:0];
          in_hi_sel = throttle_ranges_r[15:8];
          o_lo_sel  = drive_limits_r[7:0];
          o_hi_sel  = drive_limits_r[15:8];
          f_ldir    = DirFwd;
          f_rdir    = DirFwd;
        end else if (code == CodeBack) begin
          scale     = 1'b1;
          x_sel     = thr;
          in_lo_sel = throttle_ranges_r[23:16];
          in_hi_sel = throttle_ranges_r[31:24];
          o_lo_sel  = drive_limits_r[7:0];
          o_hi_sel  = drive_limits_r[15:8];
          f_ldir    = DirBack;
          f_rdir    = DirBack;
        end else begin
          scale = 1'b0;
        end
        f_dir_w = scale;
      end
    end else begin
      f_spd_w = mode2;
      f_lrst  = (code != CodeTilt) && (code != CodeStopAll);
    end
  end

  assign a_diff = {1'b0, x_sel} - {1'b0, in_lo_sel};
  assign b_diff = {1'b0, o_hi_sel} - {1'b0, o_lo_sel};
  assign d_diff = {1'b0, in_hi_sel} - {1'b0, in_lo_sel};

  // serial datapath
  logic [15:0] prod_sum;
  logic [8:0]  rem_shift;
  logic        rem_ge;
  logic [8:0]  rem_sub;
  logic [17:0] q_signed, v_sum;
  logic [7:0]  speed;
  logic        out_free;

  assign prod_sum  = prod_r + (mplier_r[0] ? mcand_r : 16'd0);
  assign rem_shift = {rem_r, qr_r[15]};
  assign rem_ge    = rem_shift >= {1'b0, den_r};
  assign rem_sub   = rem_shift - {1'b0, den_r};

  assign q_signed = neg_r ? -{2'b00, qr_r} : {2'b00, qr_r};
  assign v_sum    = q_signed + {10'd0, out_lo_r};
  always_comb begin
    priority if (v_sum[17]) begin
      speed = 8'd0;
    end else if (v_sum[16:8] != 9'd0) begin
      speed = 8'hFF;
    end else begin
      speed = v_sum[7:0];
    end
  end

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = (scale && d_diff != 9'd0) ? ST_MUL : ST_OUT;
      ST_MUL:  if (cnt_r == 4'd7) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 4'd15) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      angle_center_r    <= AngleCenterRst;
      angle_ranges_r    <= AngleRangesRst;
      throttle_ranges_r <= ThrottleRangesRst;
      turn_limits_r     <= TurnLimitsRst;
      drive_limits_r    <= DriveLimitsRst;
      link_timeout_r    <= LinkTimeoutRst;
      mode_r            <= 3'd0;
      prev_horn_r       <= 1'b0;
      silent_r          <= 16'd0;
      out_tvalid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegAngleCenter:    angle_center_r    <= cfg_data[7:0];
          RegAngleRanges:    angle_ranges_r    <= cfg_data;
          RegThrottleRanges: throttle_ranges_r <= cfg_data;
          RegTurnLimits:     turn_limits_r     <= cfg_data[15:0];
          RegDriveLimits:    drive_limits_r    <= cfg_data[15:0];
          RegLinkTimeout:    link_timeout_r    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (in_tuser) begin
          silent_r <= timeout ? 16'd0 : silent_inc;
        end else begin
          mode_r      <= mode_new;
          prev_horn_r <= horn;
          silent_r    <= 16'd0;
        end
      end
      if (state_r == ST_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          spd_w_r    <= f_spd_w;
          dir_w_r    <= f_dir_w;
          ldir_r     <= f_ldir;
          rdir_r     <= f_rdir;
          lrst_r     <= f_lrst;
          neg_r      <= a_diff[8] ^ b_diff[8] ^ d_diff[8];
          out_lo_r   <= scale ? o_lo_sel : 8'd0;
          mcand_r    <= {8'd0, abs9(a_diff)};
          mplier_r   <= abs9(b_diff);
          den_r      <= abs9(d_diff);
          prod_r     <= 16'd0;
          qr_r       <= 16'd0;
          rem_r      <= 8'd0;
          cnt_r      <= 4'd0;
        end
      end
      ST_MUL: begin
        prod_r   <= prod_sum;
        mcand_r  <= {mcand_r[14:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[7:1]};
        cnt_r    <= (cnt_r == 4'd7) ? 4'd0 : cnt_r + 4'd1;
        if (cnt_r == 4'd7) qr_r <= prod_sum;
      end
      ST_DIV: begin
        rem_r <= rem_ge ? rem_sub[7:0] : rem_shift[7:0];
        qr_r  <= {qr_r[14:0], rem_ge};
        cnt_r <= cnt_r + 4'd1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_tdata_r <= {6'd0, mode_r, lrst_r, rdir_r, ldir_r, dir_w_r,
                          (spd_w_r ? speed : 8'd0), spd_w_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire
